// File: sv/tcce_pkg.sv
`default_nettype none

package tcce_pkg;

	localparam int COLUMNS    = 80;
	localparam int ROWS       = 25;
	localparam int CELL_COUNT = COLUMNS * ROWS;
	localparam int COPY_COUNT = COLUMNS * (ROWS - 1);
	localparam int ADDR_W     = $clog2(CELL_COUNT);

	localparam int COL_W  = 7;
	localparam int ROW_W  = 5;
	localparam int IDX_W  = 12;
	localparam int CHR_W  = 8;
	localparam int CELL_W = 16;

	localparam int TAB_STEP = 4;

	localparam logic [CHR_W-1:0]  CH_TAB      = 8'h09;
	localparam logic [CHR_W-1:0]  CH_LF       = 8'h0A;
	localparam logic [CHR_W-1:0]  CH_CR       = 8'h0D;
	localparam logic [CELL_W-1:0] RESET_BLANK = 16'h0720;

	typedef enum logic [1:0] {
		CMD_PRINT = 2'd0,
		CMD_SET   = 2'd1,
		CMD_CLEAR = 2'd2,
		CMD_READ  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		SW_INIT,
		SW_CLEAR,
		SW_SCROLL
	} sweep_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_EXEC,
		ST_SWEEP,
		ST_DRAIN,
		ST_READ,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic   load_item;
		logic   do_print;
		logic   do_set;
		logic   do_clear;
		logic   do_read;
		logic   sweep_start;
		sweep_t sweep_mode;
		logic   sweep_step;
		logic   cap_read;
		logic   load_out;
	} ctl_t;

	typedef struct packed {
		cmd_t cmd;
		logic need_scroll;
		logic sweep_last;
		logic init_sweep;
		logic out_busy;
	} sts_t;

	function automatic logic [IDX_W-1:0] cell_index(input logic [ROW_W-1:0] r,
		input logic [COL_W-1:0] c);
		return IDX_W'(int'(r) * COLUMNS + int'(c));
	endfunction

endpackage

`default_nettype wire

// File: sv/text_console_cursor_engine.sv
// A non-scrolling print and set cursor go through exec and done to a registered m_tvalid;
// read cell also passes the read state. A request is taken only in idle; a result held
// by m_tready low keeps the engine in its done state and stalls the next request.
// Clear and a scrolling print sweep the cell RAM one cell per cycle.
// Reset: cursor goes to 0,0, blank cell to 0x0720; then a clearing pass over the cell RAM
// runs before the first request is taken (config writes still taken).
`default_nettype none

module text_console_cursor_engine
	import tcce_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,  // ch[7:0], color[15:8], pos_x[22:16], pos_y[27:23]
	input  wire logic [1:0]  s_tuser,  // cmd[1:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [47:0]      m_tdata,  // cursor_col[6:0], cursor_row[11:7],
	                                   // cursor_index[23:12], cell_data[39:24], scrolled[40]
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [15:0] cfg_data
);

	ctl_t ctl;
	sts_t sts;

	assign cfg_ready = 1'b1;

	tcce_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.sts     (sts),
		.ctl     (ctl)
	);

	tcce_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.sts      (sts),
		.s_tuser  (s_tuser),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_data (cfg_data)
	);

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("request taken while previous one in flight");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load_out |-> (!m_tvalid || m_tready))
		else $error("pending result overwritten");

	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[11:7] < ROW_W'(ROWS)) && (m_tdata[6:0] < COL_W'(COLUMNS)))
		else $error("cursor outside grid");

	a_single_action: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({ctl.do_print, ctl.do_set, ctl.do_clear, ctl.do_read,
			ctl.sweep_step, ctl.cap_read, ctl.load_out}))
		else $error("conflicting datapath commands");

endmodule

`default_nettype wire

// File: sv/tcce_ram.sv
`default_nettype none

module tcce_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// File: sv/tcce_ctrl.sv
`default_nettype none

module tcce_ctrl
	import tcce_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_tvalid,
	output logic      s_tready,
	input  wire sts_t sts,
	output ctl_t      ctl
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_INIT: begin
				if (sts.sweep_last) state_d = ST_DRAIN;
			end
			ST_IDLE: begin
				if (s_tvalid) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				case (sts.cmd)
					CMD_PRINT: state_d = sts.need_scroll ? ST_SWEEP : ST_DONE;
					CMD_SET:   state_d = ST_DONE;
					CMD_CLEAR: state_d = ST_SWEEP;
					CMD_READ:  state_d = ST_READ;
					default:   state_d = ST_DONE;
				endcase
			end
			ST_SWEEP: begin
				if (sts.sweep_last) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				state_d = sts.init_sweep ? ST_IDLE : ST_DONE;
			end
			ST_READ: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!sts.out_busy) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		ctl = '0;
		ctl.sweep_mode = SW_CLEAR;
		s_tready = 1'b0;
		case (state_q)
			ST_INIT: begin
				ctl.sweep_step = 1'b1;
			end
			ST_IDLE: begin
				s_tready = 1'b1;
				ctl.load_item = s_tvalid;
			end
			ST_EXEC: begin
				case (sts.cmd)
					CMD_PRINT: begin
						ctl.do_print = 1'b1;
						ctl.sweep_start = sts.need_scroll;
						ctl.sweep_mode = SW_SCROLL;
					end
					CMD_SET: begin
						ctl.do_set = 1'b1;
					end
					CMD_CLEAR: begin
						ctl.do_clear = 1'b1;
						ctl.sweep_start = 1'b1;
						ctl.sweep_mode = SW_CLEAR;
					end
					CMD_READ: begin
						ctl.do_read = 1'b1;
					end
					default: begin
						ctl.do_set = 1'b0;
					end
				endcase
			end
			ST_SWEEP: begin
				ctl.sweep_step = 1'b1;
			end
			ST_READ: begin
				ctl.cap_read = 1'b1;
			end
			ST_DONE: begin
				ctl.load_out = !sts.out_busy;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

endmodule

`default_nettype wire

// File: sv/tcce_dp.sv
`default_nettype none

module tcce_dp
	import tcce_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire ctl_t        ctl,
	output sts_t             sts,
	input  wire logic [1:0]  s_tuser,
	input  wire logic [31:0] s_tdata,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [47:0]      m_tdata,
	input  wire logic        cfg_valid,
	input  wire logic [15:0] cfg_data
);

	// item
	cmd_t              cmd_q;
	logic [CHR_W-1:0]  ch_q;
	logic [CHR_W-1:0]  color_q;
	logic [COL_W-1:0]  px_q;
	logic [ROW_W-1:0]  py_q;

	logic [CELL_W-1:0] blank_q;
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic              scroll_q;
	logic [CELL_W-1:0] data_q;

	logic [ADDR_W-1:0] cnt_q;
	sweep_t            mode_q;
	logic              wr_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic              copy_s1;

	logic              mvalid_q;
	logic [47:0]       out_q;

	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [CELL_W-1:0] ram_wdata;
	logic [ADDR_W-1:0] ram_raddr;
	logic [CELL_W-1:0] ram_rdata;

	logic              is_tab, is_cr, is_lf, printable;
	logic [COL_W:0]    col_step;
	logic              wrap;
	logic [ROW_W:0]    row_step;
	logic              need_scroll;
	logic [COL_W-1:0]  col_new;
	logic [ROW_W-1:0]  row_new;
	logic [COL_W-1:0]  px_clamp;
	logic [ROW_W-1:0]  py_clamp;
	logic              sweep_last;
	logic [CELL_W-1:0] fill_word;

	tcce_ram #(
		.WIDTH(CELL_W),
		.DEPTH(CELL_COUNT)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (ctl.load_item) begin
			cmd_q   <= cmd_t'(s_tuser);
			ch_q    <= s_tdata[7:0];
			color_q <= s_tdata[15:8];
			px_q    <= s_tdata[22:16];
			py_q    <= s_tdata[27:23];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blank_q <= RESET_BLANK;
		end else if (cfg_valid) begin
			blank_q <= cfg_data;
		end
	end

	always_comb begin
		is_tab    = (ch_q == CH_TAB);
		is_cr     = (ch_q == CH_CR);
		is_lf     = (ch_q == CH_LF);
		printable = !(is_tab || is_cr || is_lf);
		if (is_tab) begin
			col_step = {1'b0, col_q | COL_W'(TAB_STEP - 1)} + (COL_W+1)'(1);
		end else if (is_cr || is_lf) begin
			col_step = '0;
		end else begin
			col_step = {1'b0, col_q} + (COL_W+1)'(1);
		end
		wrap        = (col_step >= (COL_W+1)'(COLUMNS));
		row_step    = {1'b0, row_q} + (ROW_W+1)'(is_lf || wrap);
		need_scroll = (row_step >= (ROW_W+1)'(ROWS));
		col_new     = wrap ? '0 : col_step[COL_W-1:0];
		row_new     = need_scroll ? ROW_W'(ROWS - 1) : row_step[ROW_W-1:0];
		px_clamp    = (px_q >= COL_W'(COLUMNS)) ? COL_W'(COLUMNS - 1) : px_q;
		py_clamp    = (py_q >= ROW_W'(ROWS)) ? ROW_W'(ROWS - 1) : py_q;
		sweep_last  = (cnt_q == ADDR_W'(CELL_COUNT - 1));
		fill_word   = (mode_q == SW_INIT) ? RESET_BLANK : blank_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			scroll_q <= 1'b0;
		end else if (ctl.do_print) begin
			col_q    <= col_new;
			row_q    <= row_new;
			scroll_q <= need_scroll;
		end else if (ctl.do_set) begin
			col_q    <= px_clamp;
			row_q    <= py_clamp;
			scroll_q <= 1'b0;
		end else if (ctl.do_clear) begin
			col_q    <= '0;
			row_q    <= '0;
			scroll_q <= 1'b0;
		end else if (ctl.do_read) begin
			scroll_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.cap_read) begin
			data_q <= ram_rdata;
		end else if (ctl.do_print || ctl.do_set || ctl.do_clear || ctl.do_read) begin
			data_q <= '0;
		end
	end

	// sweep: fill after reset, clear, scroll copy plus bottom-row fill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			mode_q <= SW_INIT;
			wr_s1  <= 1'b0;
		end else if (ctl.sweep_start) begin
			cnt_q  <= '0;
			mode_q <= ctl.sweep_mode;
			wr_s1  <= 1'b0;
		end else if (ctl.sweep_step) begin
			wr_s1 <= 1'b1;
			if (!sweep_last) cnt_q <= cnt_q + ADDR_W'(1);
		end else begin
			wr_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.sweep_step) begin
			addr_s1 <= cnt_q;
			copy_s1 <= (mode_q == SW_SCROLL) && (cnt_q < ADDR_W'(COPY_COUNT));
		end
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = addr_s1;
		ram_wdata = fill_word;
		if (wr_s1) begin
			ram_we    = 1'b1;
			ram_wdata = copy_s1 ? ram_rdata : fill_word;
		end else if (ctl.do_print && printable) begin
			ram_we    = 1'b1;
			ram_waddr = ADDR_W'(cell_index(row_q, col_q));
			ram_wdata = {color_q, ch_q};
		end
		if (ctl.do_read) begin
			ram_raddr = ADDR_W'(cell_index(py_clamp, px_clamp));
		end else begin
			ram_raddr = cnt_q + ADDR_W'(COLUMNS);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mvalid_q <= 1'b0;
		end else if (ctl.load_out) begin
			mvalid_q <= 1'b1;
		end else if (m_tready) begin
			mvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_out) begin
			out_q <= {7'b0, scroll_q, data_q, cell_index(row_q, col_q), row_q, col_q};
		end
	end

	assign m_tvalid = mvalid_q;
	assign m_tdata  = out_q;

	always_comb begin
		sts.cmd         = cmd_q;
		sts.need_scroll = need_scroll;
		sts.sweep_last  = sweep_last;
		sts.init_sweep  = (mode_q == SW_INIT);
		sts.out_busy    = mvalid_q && !m_tready;
	end

endmodule

`default_nettype wire
